FILE: rtl/core/rwcs_pkg.sv
// Shared constants, types and the cosine ROM contents for the wall column shader.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package rwcs_pkg;

  localparam int TEX_SIZE   = 64;
  localparam int TEX_BITS   = $clog2(TEX_SIZE);
  localparam int FACE_WORDS = TEX_SIZE * TEX_SIZE;
  localparam int MEM_DEPTH  = 4 * FACE_WORDS;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);

  localparam int COS_DEPTH = 1024;
  localparam int COS_BITS  = $clog2(COS_DEPTH);
  localparam int IDX_MAX   = COS_DEPTH - 1;
  localparam int IDX_W     = COS_BITS + 14;
  localparam int COS_W     = 17;

  localparam int DIM_W   = 13;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 12;
  localparam int COLOR_W = 24;
  localparam int FRAC_W  = 16;
  localparam int DIST_W  = 32;

  localparam int PROD_W  = DIST_W + COS_W;
  localparam int HN_W    = PROD_W + 1;
  localparam int HGT_W   = 16;
  localparam int HCMP_W  = PROD_W + HGT_W + 1;
  localparam int HGT_LAT = COS_BITS + HGT_W + 4;

  localparam int POS_W   = 26;
  localparam int SP_W    = 32;
  localparam int JR_W    = 30;
  localparam int LOC_LAT = ROW_W + TEX_BITS + 3;

  localparam logic [63:0] ANGLE_Q32 = 64'd2473723579;
  localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_FLOOR  = 2'd2;
  localparam logic [1:0] CFG_CEIL   = 2'd3;

  typedef enum logic [1:0] {
    REGION_FLOOR = 2'd0,
    REGION_WALL  = 2'd1,
    REGION_CEIL  = 2'd2,
    REGION_BLACK = 2'd3
  } region_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] hs;
  } geom_t;

  typedef struct packed {
    logic               vld;
    logic               query;
    logic [1:0]         face;
    logic [11:0]        tidx;
    logic [COLOR_W-1:0] tcolor;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [1:0]         axis;
    logic               dir;
    logic [FRAC_W-1:0]  frac;
    logic [DIST_W-1:0]  ray_len;
  } item_t;

  typedef logic [COS_W-1:0] cos_rom_t [COS_DEPTH];

  // Taylor series of cos in Q32, Horner form, floor at each step
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t    rom;
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] u;
    for (int i = 0; i < COS_DEPTH; i++) begin
      th = (ANGLE_Q32 * 64'(i)) / 64'(IDX_MAX);
      x2 = (th * th) >> 32;
      u  = ONE_Q32;
      u  = ONE_Q32 - ((x2 * u) >> 32) / 64'd90;
      u  = ONE_Q32 - ((x2 * u) >> 32) / 64'd56;
      u  = ONE_Q32 - ((x2 * u) >> 32) / 64'd30;
      u  = ONE_Q32 - ((x2 * u) >> 32) / 64'd12;
      u  = ONE_Q32 - ((x2 * u) >> 32) / 64'd2;
      rom[i] = COS_W'((u + 64'h8000) >> 16);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

`default_nettype wire

FILE: rtl/core/rwcs_height.sv
// Wall height pipeline: column angle index, cosine ROM, distance product, height divide.
// Uses rwcs_pkg for widths, item type and ROM contents.
`default_nettype none

module rwcs_height (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire rwcs_pkg::geom_t              geom,
  input  wire rwcs_pkg::item_t              in_item,
  output rwcs_pkg::item_t                   out_item,
  output logic [rwcs_pkg::HGT_W-1:0]        out_height
);

  localparam int CB = rwcs_pkg::COS_BITS;
  localparam int IW = rwcs_pkg::IDX_W;
  localparam int HB = rwcs_pkg::HGT_W;
  localparam int HL = rwcs_pkg::HGT_LAT;

  logic [11:0]   half;
  logic [11:0]   diff;
  logic          idx_sat;
  logic [IW-1:0] den;
  logic [IW-1:0] itrial;
  logic [CB-1:0] idx;

  rwcs_pkg::item_t item_r [HL];

  logic [IW-1:0] irem_r   [CB+1];
  logic [IW-1:0] irem_nxt [CB+1];
  logic [CB-1:0] iq_r     [CB+1];
  logic [CB-1:0] iq_nxt   [CB+1];
  logic          isat_r   [CB+1];

  logic [rwcs_pkg::COS_W-1:0]  cos_r;
  logic [rwcs_pkg::PROD_W-1:0] prod_r;

  logic [rwcs_pkg::HN_W-1:0]   hrem_r   [HB+1];
  logic [rwcs_pkg::HN_W-1:0]   hrem_nxt [HB+1];
  logic [HB-1:0]               hq_r     [HB+1];
  logic [HB-1:0]               hq_nxt   [HB+1];
  logic                        hsat_r   [HB+1];
  logic                        hsat_nxt;
  logic [rwcs_pkg::PROD_W-1:0] hp_r     [HB+1];
  logic [rwcs_pkg::HCMP_W-1:0] htrial;

  always_comb begin
    half    = geom.w[12:1];
    diff    = (in_item.col > half) ? in_item.col - half : half - in_item.col;
    idx_sat = diff >= half;
    den     = IW'({half, 1'b0});
    itrial  = '0;

    // rounded ratio numerator; quotient stays below COS_DEPTH unless saturated
    irem_nxt[0] = IW'(diff) * IW'(2 * rwcs_pkg::IDX_MAX) + IW'(half);
    iq_nxt[0]   = '0;
    for (int j = 1; j <= CB; j++) begin
      itrial = den << (CB - j);
      if (irem_r[j-1] >= itrial) begin
        irem_nxt[j] = irem_r[j-1] - itrial;
        iq_nxt[j]   = iq_r[j-1] | (CB'(1) << (CB - j));
      end else begin
        irem_nxt[j] = irem_r[j-1];
        iq_nxt[j]   = iq_r[j-1];
      end
    end
    idx = isat_r[CB] ? CB'(rwcs_pkg::IDX_MAX) : iq_r[CB];

    // height = (hs*2^32 + prod/2) / prod; saturate when quotient needs more than 16 bits
    hrem_nxt[0] = (rwcs_pkg::HN_W'(geom.hs) << 32) + rwcs_pkg::HN_W'(prod_r >> 1);
    hq_nxt[0]   = '0;
    hsat_nxt    = rwcs_pkg::HCMP_W'(hrem_nxt[0]) >= (rwcs_pkg::HCMP_W'(prod_r) << HB);
    htrial      = '0;
    for (int m = 1; m <= HB; m++) begin
      htrial = rwcs_pkg::HCMP_W'(hp_r[m-1]) << (HB - m);
      if (rwcs_pkg::HCMP_W'(hrem_r[m-1]) >= htrial) begin
        hrem_nxt[m] = hrem_r[m-1] - rwcs_pkg::HN_W'(htrial);
        hq_nxt[m]   = hq_r[m-1] | (HB'(1) << (HB - m));
      end else begin
        hrem_nxt[m] = hrem_r[m-1];
        hq_nxt[m]   = hq_r[m-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < HL; s++) item_r[s].vld <= 1'b0;
    end else if (adv) begin
      item_r[0] <= in_item;
      for (int s = 1; s < HL; s++) item_r[s] <= item_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      isat_r[0] <= idx_sat;
      for (int j = 0; j <= CB; j++) begin
        irem_r[j] <= irem_nxt[j];
        iq_r[j]   <= iq_nxt[j];
      end
      for (int j = 1; j <= CB; j++) isat_r[j] <= isat_r[j-1];

      cos_r  <= rwcs_pkg::COS_ROM[idx];
      prod_r <= rwcs_pkg::PROD_W'(item_r[CB+1].ray_len) * rwcs_pkg::PROD_W'(cos_r);

      hsat_r[0] <= hsat_nxt;
      hp_r[0]   <= prod_r;
      for (int m = 0; m <= HB; m++) begin
        hrem_r[m] <= hrem_nxt[m];
        hq_r[m]   <= hq_nxt[m];
      end
      for (int m = 1; m <= HB; m++) begin
        hsat_r[m] <= hsat_r[m-1];
        hp_r[m]   <= hp_r[m-1];
      end
    end
  end

  assign out_item   = item_r[HL-1];
  assign out_height = hsat_r[HB] ? '1 : hq_r[HB];

endmodule

`default_nettype wire

FILE: rtl/core/rwcs_locate.sv
// Row placement pipeline: wall start, floor test, row offset into the slice, wall test, texel row.
// Uses rwcs_pkg for widths, item type and region codes.
`default_nettype none

module rwcs_locate (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire rwcs_pkg::geom_t               geom,
  input  wire rwcs_pkg::item_t               in_item,
  input  wire logic [rwcs_pkg::HGT_W-1:0]    in_height,
  output rwcs_pkg::item_t                    out_item,
  output rwcs_pkg::region_t                  out_cls,
  output logic [rwcs_pkg::TEX_BITS-1:0]      out_trow
);

  localparam int RB   = rwcs_pkg::ROW_W;
  localparam int TB   = rwcs_pkg::TEX_BITS;
  localparam int LL   = rwcs_pkg::LOC_LAT;
  localparam int JW   = rwcs_pkg::JR_W;
  localparam int SW   = rwcs_pkg::SP_W;
  localparam int TRW  = 17 + TB;

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] cnt0;
    logic        zero;
    logic        flr;
    logic        wall;
  } lctx_t;

  rwcs_pkg::item_t item_r [LL];
  lctx_t           ctx_r   [LL];
  lctx_t           ctx_nxt [LL];

  logic signed [SW-1:0] wsg;
  logic signed [SW-1:0] dh;
  logic signed [SW-1:0] sp_r;
  logic signed [SW-1:0] start_sum;
  logic signed [SW-1:0] start;
  logic signed [SW-1:0] dd;
  logic [rwcs_pkg::POS_W-1:0] pos_r;
  logic [15:0]                cnt0;

  logic [JW-1:0] jrem_r   [RB+1];
  logic [JW-1:0] jrem_nxt [RB+1];
  logic [RB-1:0] jq_r     [RB+1];
  logic [RB-1:0] jq_nxt   [RB+1];
  logic          jsat_r   [RB+1];
  logic          jsat_nxt;
  logic [JW-1:0] jtrial;

  logic [RB-1:0]  jj;
  logic [16:0]    kk;
  logic           wall;
  logic [TRW-1:0] trem_r   [TB+1];
  logic [TRW-1:0] trem_nxt [TB+1];
  logic [TB-1:0]  tq_r     [TB+1];
  logic [TB-1:0]  tq_nxt   [TB+1];
  logic [TRW-1:0] ttrial;

  always_comb begin
    wsg  = SW'(geom.w);
    dh   = SW'(geom.hs) - SW'(in_height);
    cnt0 = (in_height > 16'(geom.hs)) ? ((in_height - 16'(geom.hs)) >> 1) : '0;

    // truncate toward zero on halving
    start_sum = sp_r + $signed(SW'(sp_r[SW-1]));
    start     = start_sum >>> 1;
    dd        = $signed(SW'(pos_r)) - start;

    for (int s = 1; s < LL; s++) ctx_nxt[s] = ctx_r[s-1];
    ctx_nxt[0]      = '{h: in_height, cnt0: cnt0, zero: 1'b0, flr: 1'b0, wall: 1'b0};
    ctx_nxt[1].zero = ctx_r[0].h == '0;
    ctx_nxt[1].flr  = $signed(SW'(pos_r)) < start;

    // rows between the first wall row and this one: (pos - start) / w, capped by row
    jrem_nxt[0] = dd[JW-1:0];
    jq_nxt[0]   = '0;
    jsat_nxt    = jrem_nxt[0] >= (JW'(geom.w) << RB);
    jtrial      = '0;
    for (int j = 1; j <= RB; j++) begin
      jtrial = JW'(geom.w) << (RB - j);
      if (jrem_r[j-1] >= jtrial) begin
        jrem_nxt[j] = jrem_r[j-1] - jtrial;
        jq_nxt[j]   = jq_r[j-1] | (RB'(1) << (RB - j));
      end else begin
        jrem_nxt[j] = jrem_r[j-1];
        jq_nxt[j]   = jq_r[j-1];
      end
    end

    if (jsat_r[RB] || jq_r[RB] >= item_r[RB+1].row) jj = item_r[RB+1].row;
    else jj = jq_r[RB];
    kk   = 17'(ctx_r[RB+1].cnt0) + 17'(jj);
    wall = kk < 17'(ctx_r[RB+1].h);
    ctx_nxt[RB+2].wall = wall;

    // texel row = TEX_SIZE * k / h
    trem_nxt[0] = TRW'(kk) << TB;
    tq_nxt[0]   = '0;
    ttrial      = '0;
    for (int m = 1; m <= TB; m++) begin
      ttrial = TRW'(ctx_r[RB+1+m].h) << (TB - m);
      if (trem_r[m-1] >= ttrial) begin
        trem_nxt[m] = trem_r[m-1] - ttrial;
        tq_nxt[m]   = tq_r[m-1] | (TB'(1) << (TB - m));
      end else begin
        trem_nxt[m] = trem_r[m-1];
        tq_nxt[m]   = tq_r[m-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LL; s++) item_r[s].vld <= 1'b0;
    end else if (adv) begin
      item_r[0] <= in_item;
      for (int s = 1; s < LL; s++) item_r[s] <= item_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < LL; s++) ctx_r[s] <= ctx_nxt[s];
      sp_r  <= wsg * dh;
      pos_r <= rwcs_pkg::POS_W'(in_item.row) * rwcs_pkg::POS_W'(geom.w)
             + rwcs_pkg::POS_W'(in_item.col);
      jsat_r[0] <= jsat_nxt;
      for (int j = 0; j <= RB; j++) begin
        jrem_r[j] <= jrem_nxt[j];
        jq_r[j]   <= jq_nxt[j];
      end
      for (int j = 1; j <= RB; j++) jsat_r[j] <= jsat_r[j-1];
      for (int m = 0; m <= TB; m++) begin
        trem_r[m] <= trem_nxt[m];
        tq_r[m]   <= tq_nxt[m];
      end
    end
  end

  always_comb begin
    if (ctx_r[LL-1].zero)      out_cls = rwcs_pkg::REGION_CEIL;
    else if (ctx_r[LL-1].flr)  out_cls = rwcs_pkg::REGION_FLOOR;
    else if (ctx_r[LL-1].wall) out_cls = rwcs_pkg::REGION_WALL;
    else                       out_cls = rwcs_pkg::REGION_CEIL;
  end

  assign out_item = item_r[LL-1];
  assign out_trow = tq_r[TB];

endmodule

`default_nettype wire

FILE: rtl/core/rwcs_texmem.sv
// Face texture RAM and region colour select: texel writes and texel reads in one stage, keeps word order.
// Uses rwcs_pkg for sizes, item type and region codes.
`default_nettype none

module rwcs_texmem (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire rwcs_pkg::item_t                in_item,
  input  wire rwcs_pkg::region_t              in_cls,
  input  wire logic [rwcs_pkg::TEX_BITS-1:0]  in_trow,
  input  wire logic [rwcs_pkg::COLOR_W-1:0]   floor_color,
  input  wire logic [rwcs_pkg::COLOR_W-1:0]   ceil_color,
  output logic                                out_valid,
  output logic [rwcs_pkg::COLOR_W-1:0]        out_color,
  output rwcs_pkg::region_t                   out_region
);

  localparam int AW = rwcs_pkg::MEM_AW;
  localparam int TB = rwcs_pkg::TEX_BITS;

  localparam logic [1:0] FACE_SOUTH = 2'd0;
  localparam logic [1:0] FACE_NORTH = 2'd1;
  localparam logic [1:0] FACE_EAST  = 2'd2;
  localparam logic [1:0] FACE_WEST  = 2'd3;
  localparam logic [1:0] AXIS_HORZ  = 2'd0;
  localparam logic [1:0] AXIS_VERT  = 2'd1;

  logic [rwcs_pkg::COLOR_W-1:0] mem [rwcs_pkg::MEM_DEPTH];

  logic [1:0]    rface;
  logic [TB-1:0] tcol;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          wr_en;

  logic                         vld_r;
  logic                         query_r;
  logic                         face_ok_r;
  rwcs_pkg::region_t            cls_r;
  logic [rwcs_pkg::COLOR_W-1:0] rd_r;

  always_comb begin
    if (in_item.axis == AXIS_HORZ) rface = in_item.dir ? FACE_SOUTH : FACE_NORTH;
    else                           rface = in_item.dir ? FACE_EAST : FACE_WEST;
    tcol  = in_item.frac[rwcs_pkg::FRAC_W-1 -: TB];
    raddr = AW'(rface) * AW'(rwcs_pkg::FACE_WORDS) + AW'(in_trow) * AW'(rwcs_pkg::TEX_SIZE)
          + AW'(tcol);
    waddr = AW'(in_item.face) * AW'(rwcs_pkg::FACE_WORDS) + AW'(in_item.tidx);
    wr_en = adv && in_item.vld && !in_item.query
         && (32'(in_item.tidx) < rwcs_pkg::FACE_WORDS);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= in_item.tcolor;
    if (adv)   rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_item.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      query_r   <= in_item.query;
      face_ok_r <= (in_item.axis == AXIS_HORZ) || (in_item.axis == AXIS_VERT);
      cls_r     <= in_cls;
    end
  end

  always_comb begin
    out_valid = vld_r && query_r;
    case (cls_r)
      rwcs_pkg::REGION_FLOOR: begin
        out_color  = floor_color;
        out_region = rwcs_pkg::REGION_FLOOR;
      end
      rwcs_pkg::REGION_WALL: begin
        out_color  = face_ok_r ? rd_r : '0;
        out_region = face_ok_r ? rwcs_pkg::REGION_WALL : rwcs_pkg::REGION_BLACK;
      end
      default: begin
        out_color  = ceil_color;
        out_region = rwcs_pkg::REGION_CEIL;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/raycast_wall_column_shader.sv
// Path from an accepted in_ word to its out_ word: height pipeline, placement pipeline,
//   texture RAM read, output register. Texel writes pass the same stages, give no word.
// Throughput: one word per cycle; a held out_ word freezes all stages, in_tready follows it.
// Reset: clears all valid bits and loads width 640, height 480, black floor and ceiling.
//   The texture RAM is not cleared; a texel reads undefined until written.
`default_nettype none

module raycast_wall_column_shader (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // face_select[1:0], texel_index[13:2], texel_color[37:14], column[49:38], row[61:50],
  // hit_axis[63:62], hit_dir[64], hit_frac[80:65], hit_distance[112:81]
  input  wire logic [119:0] in_tdata,
  input  wire logic [0:0]   in_tuser,  // req_type[0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [23:0]       out_tdata, // pixel_color[23:0]
  output logic [1:0]        out_tuser, // region[1:0]
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [23:0]  cfg_wdata
);

  logic [rwcs_pkg::DIM_W-1:0]   width_r;
  logic [rwcs_pkg::DIM_W-1:0]   height_r;
  logic [rwcs_pkg::COLOR_W-1:0] floor_r;
  logic [rwcs_pkg::COLOR_W-1:0] ceil_r;

  logic                         adv;
  rwcs_pkg::geom_t              geom;
  rwcs_pkg::item_t              in_item;
  rwcs_pkg::item_t              hgt_item;
  logic [rwcs_pkg::HGT_W-1:0]   hgt_height;
  rwcs_pkg::item_t              loc_item;
  rwcs_pkg::region_t            loc_cls;
  logic [rwcs_pkg::TEX_BITS-1:0] loc_trow;
  logic                         tex_valid;
  logic [rwcs_pkg::COLOR_W-1:0] tex_color;
  rwcs_pkg::region_t            tex_region;

  logic                         out_valid_r;
  logic [rwcs_pkg::COLOR_W-1:0] out_color_r;
  rwcs_pkg::region_t            out_region_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd640;
      height_r <= 13'd480;
      floor_r  <= '0;
      ceil_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rwcs_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[rwcs_pkg::DIM_W-1:0];
        rwcs_pkg::CFG_HEIGHT: height_r <= cfg_wdata[rwcs_pkg::DIM_W-1:0];
        rwcs_pkg::CFG_FLOOR:  floor_r  <= cfg_wdata;
        rwcs_pkg::CFG_CEIL:   ceil_r   <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    adv       = !out_valid_r || out_tready;
    in_tready = adv;
    // narrow screens behave as width 2
    geom.w  = (width_r < 13'd2) ? 13'd2 : width_r;
    geom.hs = height_r;

    in_item.vld     = in_tvalid;
    in_item.query   = in_tuser[0];
    in_item.face    = in_tdata[1:0];
    in_item.tidx    = in_tdata[13:2];
    in_item.tcolor  = in_tdata[37:14];
    in_item.col     = in_tdata[49:38];
    in_item.row     = in_tdata[61:50];
    in_item.axis    = in_tdata[63:62];
    in_item.dir     = in_tdata[64];
    in_item.frac    = in_tdata[80:65];
    in_item.ray_len = in_tdata[112:81];
  end

  rwcs_height u_height (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .geom       (geom),
    .in_item    (in_item),
    .out_item   (hgt_item),
    .out_height (hgt_height)
  );

  rwcs_locate u_locate (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .geom      (geom),
    .in_item   (hgt_item),
    .in_height (hgt_height),
    .out_item  (loc_item),
    .out_cls   (loc_cls),
    .out_trow  (loc_trow)
  );

  rwcs_texmem u_texmem (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_item     (loc_item),
    .in_cls      (loc_cls),
    .in_trow     (loc_trow),
    .floor_color (floor_r),
    .ceil_color  (ceil_r),
    .out_valid   (tex_valid),
    .out_color   (tex_color),
    .out_region  (tex_region)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_color_r  <= tex_color;
      out_region_r <= tex_region;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;
  assign out_tuser  = out_region_r;

endmodule

`default_nettype wire
